>>> src/nfrp_pkg.sv
// ----------------------------------------------------------------------------
// nfrp_pkg
// Shared widths, register indexes and pipeline types for the nearest-fit
// rectangle placement block.
// ----------------------------------------------------------------------------
package nfrp_pkg;

    // Field widths
    localparam int COORD_W    = 16;   // signed coordinates
    localparam int DIM_W      = 16;   // unsigned sizes
    localparam int ORD_W      = 8;    // reported ordinal
    localparam int DIST_W     = 34;   // kept squared distance
    localparam int OUT_DIST_W = 33;   // reported squared distance
    localparam int DELTA_W    = COORD_W + 1;   // want minus candidate
    localparam int LIMIT_W    = COORD_W + 2;   // corner plus spare room
    localparam int SQ_W       = 2 * COORD_W;   // one squared delta
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default list length limit
    localparam int MAX_RECTS_DEF = 256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_WIDTH  = 2'd0,
        REG_WINDOW_HEIGHT = 2'd1,
        REG_WANT_X        = 2'd2,
        REG_WANT_Y        = 2'd3
    } cfg_reg_t;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic             valid;  // stage holds a request
        logic             cand;   // request still counts as a candidate
        logic             last;   // request closes the list
        logic [ORD_W-1:0] ord;    // arrival number, low bits
    } stage_ctl_t;

endpackage

>>> src/nfrp_if.sv
// ----------------------------------------------------------------------------
// nfrp channel interfaces
// Valid/ready channels for the rectangle stream and the placement result.
// ----------------------------------------------------------------------------
interface nfrp_rect_if;
    import nfrp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      rect_present;
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic        [DIM_W-1:0]   rect_width;
    logic        [DIM_W-1:0]   rect_height;
    logic                      last_rect;

    modport source (
        output valid, rect_present, rect_x, rect_y, rect_width, rect_height, last_rect,
        input  ready
    );
    modport sink (
        input  valid, rect_present, rect_x, rect_y, rect_width, rect_height, last_rect,
        output ready
    );
endinterface

interface nfrp_place_if;
    import nfrp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [COORD_W-1:0] place_x;
    logic signed [COORD_W-1:0] place_y;
    logic        [ORD_W-1:0]   chosen_ordinal;
    logic        [OUT_DIST_W-1:0] distance_sq;

    modport source (
        output valid, found, place_x, place_y, chosen_ordinal, distance_sq,
        input  ready
    );
    modport sink (
        input  valid, found, place_x, place_y, chosen_ordinal, distance_sq,
        output ready
    );
endinterface

>>> src/nearest_fit_rect_position_top.sv
// ----------------------------------------------------------------------------
// nearest_fit_rect_position_top
// Nearest-fit window placement over a stream of free rectangles.
// ----------------------------------------------------------------------------
// Usage
//   rect_in carries one free rectangle per request; last_rect closes a list,
//   and a request with rect_present low carries no rectangle (it may still
//   close the list). place_out gives one result per list, on its last request.
//   Window size and wanted position are written through cfg_we / cfg_index /
//   cfg_wdata while no list is in flight.
// Timing
//   Five register stages: input, fit and limit, delta, square, running best.
//   A result is registered from the closing request as it leaves the square
//   stage. One request is taken every cycle while the input is not stalled;
//   the running-minimum compare in the last stage closes a loop on the best.
// Reset
//   rst_n clears the configuration, the stage valid flags, the running best
//   flag, the result valid and the rectangle count; data registers load first.
// Stalls
//   The result register decouples the sides: requests keep flowing while a
//   result waits. rect_in.ready drops only when a second closing request
//   reaches the last stage while the earlier result is still not taken.
// ----------------------------------------------------------------------------
module nearest_fit_rect_position_top #(
    parameter int MAX_RECTS = nfrp_pkg::MAX_RECTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nfrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    nfrp_rect_if.sink                       rect_in,
    nfrp_place_if.source                    place_out
);
    import nfrp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int ORDX_W = (CNT_W > ORD_W) ? CNT_W : ORD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [DIM_W-1:0]   win_w_reg;
    logic        [DIM_W-1:0]   win_h_reg;
    logic signed [COORD_W-1:0] want_x_reg;
    logic signed [COORD_W-1:0] want_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg  <= '0;
            win_h_reg  <= '0;
            want_x_reg <= '0;
            want_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_WIDTH:  win_w_reg  <= DIM_W'(cfg_wdata);
                REG_WINDOW_HEIGHT: win_h_reg  <= DIM_W'(cfg_wdata);
                REG_WANT_X:        want_x_reg <= COORD_W'(cfg_wdata);
                REG_WANT_Y:        want_y_reg <= COORD_W'(cfg_wdata);
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: hold only when a closing request meets a full
    // result register that is not being emptied
    // ------------------------------------------------------------------
    stage_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       take_in;

    assign advance = !(s4_ctl_reg.valid && s4_ctl_reg.last && out_valid_reg
                       && !place_out.ready);
    assign rect_in.ready = advance;
    assign take_in       = rect_in.valid && advance;

    // ------------------------------------------------------------------
    // Rectangle count and arrival number
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              counted;
    logic [ORDX_W-1:0] ord_ext;
    stage_ctl_t        s1_ctl_next;

    assign counted = rect_in.rect_present && (cnt_reg < CNT_W'(MAX_RECTS));
    assign ord_ext = ORDX_W'(cnt_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take_in)
        begin
            if (rect_in.last_rect)
                cnt_next = '0;
            else if (counted)
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        s1_ctl_next.valid = rect_in.valid;
        s1_ctl_next.cand  = counted;
        s1_ctl_next.last  = rect_in.last_rect;
        s1_ctl_next.ord   = ord_ext[ORD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] s1_rx_reg, s1_ry_reg;
    logic        [DIM_W-1:0]   s1_rw_reg, s1_rh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            s1_ctl_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg    <= cnt_next;
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_rx_reg <= rect_in.rect_x;
            s1_ry_reg <= rect_in.rect_y;
            s1_rw_reg <= rect_in.rect_width;
            s1_rh_reg <= rect_in.rect_height;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fit test and furthest corner the window may move to
    // ------------------------------------------------------------------
    logic                      fits;
    logic        [DIM_W-1:0]   room_x, room_y;
    logic signed [LIMIT_W-1:0] lim_x_next, lim_y_next;
    logic signed [LIMIT_W-1:0] s2_lim_x_reg, s2_lim_y_reg;
    logic signed [COORD_W-1:0] s2_rx_reg, s2_ry_reg;
    stage_ctl_t                s2_ctl_next;

    assign fits   = (s1_rw_reg >= win_w_reg) && (s1_rh_reg >= win_h_reg);
    assign room_x = s1_rw_reg - win_w_reg;
    assign room_y = s1_rh_reg - win_h_reg;
    assign lim_x_next = {{(LIMIT_W-COORD_W){s1_rx_reg[COORD_W-1]}}, s1_rx_reg}
                      + $signed({{(LIMIT_W-DIM_W){1'b0}}, room_x});
    assign lim_y_next = {{(LIMIT_W-COORD_W){s1_ry_reg[COORD_W-1]}}, s1_ry_reg}
                      + $signed({{(LIMIT_W-DIM_W){1'b0}}, room_y});

    // Candidate survives only if the window fits
    always_comb
    begin
        s2_ctl_next      = s1_ctl_reg;
        s2_ctl_next.cand = s1_ctl_reg.cand && fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctl_reg <= '0;
        else if (advance)
            s2_ctl_reg <= s2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_rx_reg    <= s1_rx_reg;
            s2_ry_reg    <= s1_ry_reg;
            s2_lim_x_reg <= lim_x_next;
            s2_lim_y_reg <= lim_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pull the corner toward the wish, take the deltas
    // ------------------------------------------------------------------
    logic signed [LIMIT_W-1:0] want_x_ext, want_y_ext;
    logic signed [COORD_W-1:0] cx, cy;
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    logic signed [COORD_W-1:0] s3_cx_reg, s3_cy_reg;
    logic signed [DELTA_W-1:0] s3_dx_reg, s3_dy_reg;

    assign want_x_ext = {{(LIMIT_W-COORD_W){want_x_reg[COORD_W-1]}}, want_x_reg};
    assign want_y_ext = {{(LIMIT_W-COORD_W){want_y_reg[COORD_W-1]}}, want_y_reg};

    // The pulled value never exceeds the wish, so it fits a coordinate
    always_comb
    begin
        cx = s2_rx_reg;
        if (s2_rx_reg < want_x_reg)
            cx = (want_x_ext < s2_lim_x_reg) ? want_x_reg : s2_lim_x_reg[COORD_W-1:0];
        cy = s2_ry_reg;
        if (s2_ry_reg < want_y_reg)
            cy = (want_y_ext < s2_lim_y_reg) ? want_y_reg : s2_lim_y_reg[COORD_W-1:0];
    end

    assign dx_next = {want_x_reg[COORD_W-1], want_x_reg} - {cx[COORD_W-1], cx};
    assign dy_next = {want_y_reg[COORD_W-1], want_y_reg} - {cy[COORD_W-1], cy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_ctl_reg <= '0;
        else if (advance)
            s3_ctl_reg <= s2_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_cx_reg <= cx;
            s3_cy_reg <= cy;
            s3_dx_reg <= dx_next;
            s3_dy_reg <= dy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: square the deltas
    // ------------------------------------------------------------------
    logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
    logic        [SQ_W-1:0]      s4_sqx_reg, s4_sqy_reg;
    logic signed [COORD_W-1:0]   s4_cx_reg, s4_cy_reg;

    assign sqx_full = s3_dx_reg * s3_dx_reg;
    assign sqy_full = s3_dy_reg * s3_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_ctl_reg <= '0;
        else if (advance)
            s4_ctl_reg <= s3_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_sqx_reg <= sqx_full[SQ_W-1:0];
            s4_sqy_reg <= sqy_full[SQ_W-1:0];
            s4_cx_reg  <= s3_cx_reg;
            s4_cy_reg  <= s3_cy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: running best; later candidate wins a tie
    // ------------------------------------------------------------------
    logic                      best_valid_reg, best_valid_next;
    logic signed [COORD_W-1:0] best_x_reg, best_x_next;
    logic signed [COORD_W-1:0] best_y_reg, best_y_next;
    logic        [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic        [ORD_W-1:0]   best_ord_reg, best_ord_next;
    logic        [DIST_W-1:0]  cand_dist;
    logic                      keep;
    logic                      close;

    assign cand_dist = DIST_W'(s4_sqx_reg) + DIST_W'(s4_sqy_reg);
    assign keep  = s4_ctl_reg.valid && s4_ctl_reg.cand
                   && (!best_valid_reg || (cand_dist <= best_dist_reg));
    assign close = advance && s4_ctl_reg.valid && s4_ctl_reg.last;

    // Merged best including this request
    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_dist_next  = best_dist_reg;
        best_ord_next   = best_ord_reg;
        if (keep)
        begin
            best_valid_next = 1'b1;
            best_x_next     = s4_cx_reg;
            best_y_next     = s4_cy_reg;
            best_dist_next  = cand_dist;
            best_ord_next   = s4_ctl_reg.ord;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_valid_reg <= 1'b0;
        else if (close)
            best_valid_reg <= 1'b0;
        else if (advance)
            best_valid_reg <= best_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_dist_reg <= best_dist_next;
            best_ord_reg  <= best_ord_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                         out_valid_next;
    logic                         out_found_reg;
    logic signed [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic        [ORD_W-1:0]      out_ord_reg;
    logic        [OUT_DIST_W-1:0] out_dist_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (close)
            out_valid_next = 1'b1;
        else if (place_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Nothing fitted: report the wish with zero ordinal and distance
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            out_found_reg <= best_valid_next;
            if (best_valid_next)
            begin
                out_x_reg    <= best_x_next;
                out_y_reg    <= best_y_next;
                out_ord_reg  <= best_ord_next;
                out_dist_reg <= best_dist_next[OUT_DIST_W-1:0];
            end
            else
            begin
                out_x_reg    <= want_x_reg;
                out_y_reg    <= want_y_reg;
                out_ord_reg  <= '0;
                out_dist_reg <= '0;
            end
        end
    end

    assign place_out.valid          = out_valid_reg;
    assign place_out.found          = out_found_reg;
    assign place_out.place_x        = out_x_reg;
    assign place_out.place_y        = out_y_reg;
    assign place_out.chosen_ordinal = out_ord_reg;
    assign place_out.distance_sq    = out_dist_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input holds back only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rect_in.ready |-> (out_valid_reg && !place_out.ready))
        else $error("input stalled without a blocked result");

    // A new result only follows a closing request in the last stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_ctl_reg.valid && s4_ctl_reg.last))
        else $error("result raised without a closing request");

    // No-fit result carries zero ordinal and distance
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_ord_reg == '0 && out_dist_reg == '0))
        else $error("no-fit result with non-zero ordinal or distance");

    // Rectangle count saturates at the list limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECTS))
        else $error("rectangle count beyond limit");

endmodule
